@@ design/lf_pkg.sv @@
package lf_pkg;

	localparam int MAX_SIZE = 64;
	localparam int ROW_W = 64;
	localparam int ADDR_W = $clog2(MAX_SIZE);
	localparam int GS_W = 7;
	localparam int CNT_W = $clog2(MAX_SIZE + 2);
	localparam int LANE_W = 16;
	localparam int LANES = ROW_W / LANE_W;
	localparam int NBR_W = 4;
	localparam int UNDER_LIMIT = 2;
	localparam int OVER_LIMIT = 3;

	localparam logic [1:0] REQ_WRITE = 2'd0;
	localparam logic [1:0] REQ_READ = 2'd1;
	localparam logic [1:0] REQ_ADVANCE = 2'd2;

	typedef enum logic {
		ST_IDLE,
		ST_ADV
	} state_t;

	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		logic [ROW_W-1:0]  wdata;
		logic              re;
		logic [ADDR_W-1:0] raddr;
	} buf_req_t;

	function automatic logic [ROW_W-1:0] col_mask(input logic [GS_W-1:0] n);
		logic [ROW_W-1:0] m;
		if (n >= GS_W'(ROW_W)) begin
			m = '1;
		end else begin
			m = (ROW_W'(1) << n) - ROW_W'(1);
		end
		return m;
	endfunction

endpackage

@@ design/life_grid_generation_engine_top.sv @@
// Conway Life engine, two row buffers of 64 rows by 64 cells. Issue a request with start while
// busy is low; its single result shows on done for one cycle and must be taken then, as the
// block has no way to hold it. A row write or read passes through a pending register and then
// the done register, and busy is high while it is pending. In an advance one source row
// is read per cycle from the single read port of the current buffer, four 16-column lanes
// compute a full next-generation row per cycle from a three-row window, and the row goes into
// the other buffer after the buffer read register and the row window.
module life_grid_generation_engine_top import lf_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  logic [1:0]       req_type,
	input  logic [5:0]       row_index,
	input  logic [ROW_W-1:0] row_cells,
	output logic             done,
	output logic [ROW_W-1:0] row_cells_out,
	output logic             out_of_range,
	input  logic             grid_size_we,
	input  logic [GS_W-1:0]  grid_size
);

	state_t            state_q, state_d;
	logic [GS_W-1:0]   grid_size_q;
	logic [GS_W-1:0]   n;
	logic [ROW_W-1:0]  m;
	logic              cur_sel_q;
	logic              acc, iss, iss_rd, oor, host_wr, host_rd;
	logic [CNT_W-1:0]  cnt_q;
	logic              v_s1, v_s2;
	logic [CNT_W-1:0]  row_s1, row_s2;
	logic [ROW_W-1:0]  up_q, mid_q, dn_q;
	logic [ROW_W-1:0]  src_row, cur_rdata, rdata_a, rdata_b, merged, adv_wdata;
	logic [ROW_W+1:0]  up_x, mid_x, dn_x;
	logic [CNT_W-1:0]  ctr_full;
	logic              adv_we, adv_last;
	logic              pend_q, pend_oor_q;
	logic [1:0]        pend_type_q;
	logic              done_q, out_of_range_q;
	logic [ROW_W-1:0]  row_cells_out_q;
	buf_req_t          req_a, req_b, host_req, adv_req;

	assign n = (grid_size_q > GS_W'(MAX_SIZE)) ? GS_W'(MAX_SIZE) : grid_size_q;
	assign m = col_mask(n);

	// state machine
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (acc && (req_type == REQ_ADVANCE)) begin
					state_d = ST_ADV;
				end
			end
			ST_ADV: begin
				if (adv_last) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		busy = 1'b1;
		iss  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				busy = pend_q;
			end
			ST_ADV: begin
				iss = (cnt_q <= CNT_W'(MAX_SIZE));
			end
			default: begin
				busy = 1'b1;
			end
		endcase
	end

	assign acc     = start && !busy;
	assign oor     = ((req_type == REQ_WRITE) || (req_type == REQ_READ)) &&
		(GS_W'(row_index) >= n);
	assign host_wr = acc && (req_type == REQ_WRITE) && !oor;
	assign host_rd = acc && (req_type == REQ_READ) && !oor;
	assign iss_rd  = iss && (cnt_q < CNT_W'(MAX_SIZE));

	// buffers: reads always hit the current one, an advance writes the other
	always_comb begin
		host_req.we    = host_wr;
		host_req.waddr = row_index[ADDR_W-1:0];
		host_req.wdata = row_cells & m;
		host_req.re    = host_rd || iss_rd;
		host_req.raddr = iss_rd ? cnt_q[ADDR_W-1:0] : row_index[ADDR_W-1:0];

		adv_req.we    = adv_we;
		adv_req.waddr = ctr_full[ADDR_W-1:0];
		adv_req.wdata = adv_wdata;
		adv_req.re    = 1'b0;
		adv_req.raddr = '0;

		req_a = cur_sel_q ? adv_req : host_req;
		req_b = cur_sel_q ? host_req : adv_req;
	end

	lf_row_buf u_buf_a (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_a),
		.rdata (rdata_a)
	);

	lf_row_buf u_buf_b (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_b),
		.rdata (rdata_b)
	);

	assign cur_rdata = cur_sel_q ? rdata_b : rdata_a;
	assign src_row   = (GS_W'(row_s1) < n) ? (cur_rdata & m) : '0;

	// row window and lanes
	assign up_x  = {1'b0, up_q, 1'b0};
	assign mid_x = {1'b0, mid_q, 1'b0};
	assign dn_x  = {1'b0, dn_q, 1'b0};

	for (genvar l = 0; l < LANES; l++) begin : g_lane
		lf_lane u_lane (
			.up (up_x[l*LANE_W +: LANE_W+2]),
			.mid(mid_x[l*LANE_W +: LANE_W+2]),
			.dn (dn_x[l*LANE_W +: LANE_W+2]),
			.nxt(merged[l*LANE_W +: LANE_W])
		);
	end

	assign ctr_full  = row_s2 - CNT_W'(1);
	assign adv_wdata = (GS_W'(ctr_full) < n) ? (merged & m) : '0;
	assign adv_we    = v_s2 && (row_s2 != '0);
	assign adv_last  = v_s2 && (row_s2 == CNT_W'(MAX_SIZE));

	always_ff @(posedge clk) begin
		if (acc && (req_type == REQ_ADVANCE)) begin
			up_q  <= '0;
			mid_q <= '0;
			dn_q  <= '0;
		end else if (v_s1) begin
			up_q  <= mid_q;
			mid_q <= dn_q;
			dn_q  <= src_row;
		end
		row_s1      <= cnt_q;
		row_s2      <= row_s1;
		pend_type_q <= req_type;
		pend_oor_q  <= oor;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_IDLE;
			grid_size_q     <= GS_W'(MAX_SIZE);
			cur_sel_q       <= 1'b0;
			cnt_q           <= '0;
			v_s1            <= 1'b0;
			v_s2            <= 1'b0;
			pend_q          <= 1'b0;
			done_q          <= 1'b0;
			out_of_range_q  <= 1'b0;
			row_cells_out_q <= '0;
		end else begin
			state_q <= state_d;
			if (grid_size_we) begin
				grid_size_q <= grid_size;
			end
			if (adv_last) begin
				cur_sel_q <= !cur_sel_q;
			end
			if (acc && (req_type == REQ_ADVANCE)) begin
				cnt_q <= '0;
			end else if (iss) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
			v_s1            <= iss;
			v_s2            <= v_s1;
			pend_q          <= acc && (req_type != REQ_ADVANCE);
			done_q          <= pend_q || adv_last;
			out_of_range_q  <= pend_q && pend_oor_q;
			row_cells_out_q <= (pend_q && (pend_type_q == REQ_READ) && !pend_oor_q) ?
				(cur_rdata & m) : '0;
		end
	end

	assign done          = done_q;
	assign out_of_range  = out_of_range_q;
	assign row_cells_out = row_cells_out_q;

	a_row_req_latency: assert property (@(posedge clk) disable iff (!arst_n)
		acc && (req_type != REQ_ADVANCE) |=> !done ##1 done)
		else $error("row request result timing wrong");

	a_sel_only_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		!adv_last |=> $stable(cur_sel_q))
		else $error("buffer select changed outside advance end");

	a_one_writer: assert property (@(posedge clk) disable iff (!arst_n)
		!(req_a.we && req_b.we))
		else $error("both buffers written in one cycle");

	a_oor_with_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_of_range |-> done)
		else $error("out_of_range without result strobe");

	a_adv_no_host: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ADV) |-> !host_wr && !acc)
		else $error("transfer taken during advance");

endmodule

@@ design/lf_row_buf.sv @@
module lf_row_buf import lf_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  buf_req_t         req,
	output logic [ROW_W-1:0] rdata
);

	logic [ROW_W-1:0]    mem [MAX_SIZE];
	logic [MAX_SIZE-1:0] valid_q;
	logic [ROW_W-1:0]    rdata_q;
	logic                rvalid_q;

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
		if (req.re) begin
			rdata_q <= mem[req.raddr];
		end
	end

	// rows never written since reset read as dead
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			rvalid_q <= 1'b0;
		end else begin
			if (req.we) begin
				valid_q[req.waddr] <= 1'b1;
			end
			if (req.re) begin
				rvalid_q <= valid_q[req.raddr];
			end
		end
	end

	assign rdata = rvalid_q ? rdata_q : '0;

endmodule

@@ design/lf_lane.sv @@
module lf_lane import lf_pkg::*; (
	input  logic [LANE_W+1:0] up,
	input  logic [LANE_W+1:0] mid,
	input  logic [LANE_W+1:0] dn,
	output logic [LANE_W-1:0] nxt
);

	always_comb begin
		logic [NBR_W-1:0] cnt;
		for (int i = 0; i < LANE_W; i++) begin
			cnt = NBR_W'(up[i]) + NBR_W'(up[i+1]) + NBR_W'(up[i+2])
				+ NBR_W'(mid[i]) + NBR_W'(mid[i+2])
				+ NBR_W'(dn[i]) + NBR_W'(dn[i+1]) + NBR_W'(dn[i+2]);
			nxt[i] = (cnt == NBR_W'(OVER_LIMIT)) || ((cnt == NBR_W'(UNDER_LIMIT)) && mid[i+1]);
		end
	end

endmodule

@@ sim/life_grid_generation_engine_checker.sv @@
`timescale 1ns / 1ps

module life_grid_generation_engine_checker import lf_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic             busy,
	input  logic [1:0]       req_type,
	input  logic [5:0]       row_index,
	input  logic [ROW_W-1:0] row_cells,
	input  logic             done,
	input  logic [ROW_W-1:0] row_cells_out,
	input  logic             out_of_range,
	input  logic             grid_size_we,
	input  logic [GS_W-1:0]  grid_size,
	output int               mismatches,
	output int               awaiting
);

	typedef struct {
		logic [ROW_W-1:0] cells;
		logic             oor;
	} row_result_t;

	row_result_t      row_result_q[$];
	logic [ROW_W-1:0] gen_rows [2][MAX_SIZE];
	logic             front;
	logic [GS_W-1:0]  side_reg;
	int               errors;

	function automatic logic [ROW_W-1:0] visible_mask(input int n);
		if (n >= ROW_W) begin
			return '1;
		end
		return (ROW_W'(1) << n) - ROW_W'(1);
	endfunction

	function automatic logic [ROW_W-1:0] next_row(input logic [ROW_W-1:0] up,
			input logic [ROW_W-1:0] mid, input logic [ROW_W-1:0] dn, input int n);
		logic [ROW_W-1:0] r;
		int cnt;
		r = '0;
		for (int x = 0; x < n; x++) begin
			cnt = int'(up[x]) + int'(dn[x]);
			if (x > 0) begin
				cnt += int'(up[x-1]) + int'(mid[x-1]) + int'(dn[x-1]);
			end
			if (x < ROW_W - 1) begin
				cnt += int'(up[x+1]) + int'(mid[x+1]) + int'(dn[x+1]);
			end
			r[x] = (cnt == OVER_LIMIT) || (cnt == UNDER_LIMIT && mid[x]);
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin : predict
		row_result_t want;
		int n;
		logic [ROW_W-1:0] m;
		logic [ROW_W-1:0] up;
		logic [ROW_W-1:0] dn;
		if (!arst_n) begin
			for (int y = 0; y < MAX_SIZE; y++) begin
				gen_rows[0][y] = '0;
				gen_rows[1][y] = '0;
			end
			front = 1'b0;
			side_reg = GS_W'(MAX_SIZE);
			errors = 0;
			row_result_q.delete();
			mismatches <= 0;
			awaiting <= 0;
		end else begin
			// result first: nothing accepted at this edge can complete at it
			if (done) begin
				if (row_result_q.size() == 0) begin
					errors++;
					if (errors <= 10) begin
						$display("%0t: result with no request pending: cells %h oor %b",
							$realtime, row_cells_out, out_of_range);
					end
				end else begin
					want = row_result_q.pop_front();
					if (row_cells_out !== want.cells || out_of_range !== want.oor) begin
						errors++;
						if (errors <= 10) begin
							$display("%0t: mismatch: cells %h oor %b, expected cells %h oor %b",
								$realtime, row_cells_out, out_of_range, want.cells, want.oor);
						end
					end
				end
			end
			if (grid_size_we) begin
				side_reg = grid_size;
			end
			if (start && !busy) begin
				n = (side_reg > MAX_SIZE) ? MAX_SIZE : int'(side_reg);
				m = visible_mask(n);
				want.cells = '0;
				want.oor = 1'b0;
				case (req_type)
					REQ_WRITE, REQ_READ: begin
						if (int'(row_index) >= n) begin
							want.oor = 1'b1;
						end else if (req_type == REQ_WRITE) begin
							gen_rows[front][row_index] = row_cells & m;
						end else begin
							want.cells = gen_rows[front][row_index] & m;
						end
					end
					REQ_ADVANCE: begin
						for (int y = 0; y < MAX_SIZE; y++) begin
							if (y >= n) begin
								gen_rows[!front][y] = '0;
							end else begin
								up = (y > 0) ? (gen_rows[front][y-1] & m) : '0;
								dn = (y + 1 < n) ? (gen_rows[front][y+1] & m) : '0;
								gen_rows[!front][y] = next_row(up, gen_rows[front][y] & m, dn, n);
							end
						end
						front = !front;
					end
					default: begin
					end
				endcase
				row_result_q.push_back(want);
			end
			mismatches <= errors;
			awaiting <= row_result_q.size();
		end
	end

endmodule

@@ sim/life_grid_generation_engine_top_test.sv @@
`timescale 1ns / 1ps

module life_grid_generation_engine_top_test;
	import lf_pkg::*;

	localparam logic [1:0] REQ_UNUSED = 2'd3;
	localparam int RANDOM_ITEMS = 1750;
	localparam int CYCLE_LIMIT = 1500000;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             start = 1'b0;
	logic [1:0]       req_type = REQ_WRITE;
	logic [5:0]       row_index = '0;
	logic [ROW_W-1:0] row_cells = '0;
	logic             grid_size_we = 1'b0;
	logic [GS_W-1:0]  grid_size = GS_W'(MAX_SIZE);
	logic             busy;
	logic             done;
	logic [ROW_W-1:0] row_cells_out;
	logic             out_of_range;
	int               mismatches;
	int               awaiting;

	int  side = MAX_SIZE;
	bit  quiet = 1'b0;
	int  cycles = 0;
	int  n_writes = 0;
	int  n_reads = 0;
	int  n_advances = 0;
	int  n_ignored = 0;
	int  n_sizes = 0;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	life_grid_generation_engine_top i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.req_type      (req_type),
		.row_index     (row_index),
		.row_cells     (row_cells),
		.done          (done),
		.row_cells_out (row_cells_out),
		.out_of_range  (out_of_range),
		.grid_size_we  (grid_size_we),
		.grid_size     (grid_size)
	);

	life_grid_generation_engine_checker i_life_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.req_type      (req_type),
		.row_index     (row_index),
		.row_cells     (row_cells),
		.done          (done),
		.row_cells_out (row_cells_out),
		.out_of_range  (out_of_range),
		.grid_size_we  (grid_size_we),
		.grid_size     (grid_size),
		.mismatches    (mismatches),
		.awaiting      (awaiting)
	);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// one request transfer; start stays high for a following request
	task automatic issue(input logic [1:0] kind, input int row, input logic [ROW_W-1:0] cells);
		if (!quiet && $urandom_range(0, 99) < 7) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		start <= 1'b1;
		req_type <= kind;
		row_index <= 6'(row);
		row_cells <= cells;
		do @(posedge clk); while (busy);
		if (kind == REQ_ADVANCE) begin
			n_advances++;
		end else if (kind == REQ_UNUSED || row >= side) begin
			n_ignored++;
		end else if (kind == REQ_WRITE) begin
			n_writes++;
		end else begin
			n_reads++;
		end
	endtask

	task automatic drain();
		start <= 1'b0;
		do @(posedge clk); while (awaiting != 0 || busy);
		repeat (6) @(posedge clk);
	endtask

	task automatic set_size(input int v);
		drain();
		grid_size_we <= 1'b1;
		grid_size <= GS_W'(v);
		@(posedge clk);
		grid_size_we <= 1'b0;
		side = (v > MAX_SIZE) ? MAX_SIZE : v;
		n_sizes++;
	endtask

	function automatic logic [ROW_W-1:0] rand_row();
		case ($urandom_range(0, 5))
			0: return '1;
			1: return '0;
			2: return {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
			3: return ROW_W'(7) << $urandom_range(0, ROW_W - 3);
			default: return {$urandom, $urandom};
		endcase
	endfunction

	initial begin : stimulus
		int base;
		int phase;
		int len;
		int pick;
		int row;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// corners, edges and the unused request at full size
		issue(REQ_WRITE, 0, '1);
		issue(REQ_WRITE, 63, '1);
		issue(REQ_READ, 0, '0);
		issue(REQ_READ, 63, '0);
		issue(REQ_UNUSED, 5, {$urandom, $urandom});
		issue(REQ_WRITE, 1, 64'h8000_0000_0000_0001);
		issue(REQ_ADVANCE, 0, '0);
		issue(REQ_READ, 0, '0);
		issue(REQ_READ, 1, '0);
		issue(REQ_READ, 63, '0);
		// blinker on a 3x3 grid, high bits dropped
		set_size(3);
		issue(REQ_WRITE, 1, '1);
		issue(REQ_WRITE, 3, '1);
		issue(REQ_READ, 3, '0);
		issue(REQ_ADVANCE, 0, '0);
		issue(REQ_READ, 0, '0);
		issue(REQ_READ, 2, '0);
		issue(REQ_ADVANCE, 0, '0);
		issue(REQ_READ, 1, '0);
		// empty grid, then saturated size, then single cell
		set_size(0);
		issue(REQ_WRITE, 0, '1);
		issue(REQ_ADVANCE, 0, '0);
		set_size(127);
		issue(REQ_READ, 63, '0);
		set_size(1);
		issue(REQ_WRITE, 0, '1);
		issue(REQ_READ, 0, '0);

		base = n_writes + n_reads + n_advances;
		phase = 0;
		while (n_writes + n_reads + n_advances < base + RANDOM_ITEMS) begin
			case ($urandom_range(0, 9))
				0: set_size(MAX_SIZE);
				1: set_size(1);
				2: set_size(2);
				3: set_size(3);
				4: set_size($urandom_range(0, 9) == 0 ? 0 : $urandom_range(65, 127));
				default: set_size($urandom_range(4, 63));
			endcase
			quiet = (phase >= 4 && phase < 8);
			// seed the grid, then a mix of reads, writes and generations
			for (int y = 0; y < side; y++) begin
				if ($urandom_range(0, 2) != 0) begin
					issue(REQ_WRITE, y, rand_row());
				end
			end
			len = $urandom_range(30, 90);
			for (int k = 0; k < len; k++) begin
				pick = $urandom_range(0, 99);
				row = (side == 0 || $urandom_range(0, 9) == 0) ?
					$urandom_range(0, 63) : $urandom_range(0, side - 1);
				if (pick < 25) begin
					issue(REQ_WRITE, row, rand_row());
				end else if (pick < 70) begin
					issue(REQ_READ, row, {$urandom, $urandom});
				end else if (pick < 96) begin
					issue(REQ_ADVANCE, row, {$urandom, $urandom});
				end else begin
					issue(REQ_UNUSED, row, {$urandom, $urandom});
				end
			end
			phase++;
		end

		drain();
		$display("covered %0d row writes, %0d row reads, %0d generations, %0d ignored requests",
			n_writes, n_reads, n_advances, n_ignored);
		$display("over %0d grid size settings in %0d cycles", n_sizes, cycles);
		if (mismatches == 0 && awaiting == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
